>>> hw/rtl/pws_pkg.sv
// pws_pkg: shared constants, widths and controller/datapath structs
// for the window scan unit; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pws_pkg;

  // table geometry
  localparam int MAX_MOTIF_LENGTH = 64;
  localparam int ALPHABET_SIZE    = 32;
  localparam int COL_W            = 6;
  localparam int SYM_W            = 5;
  localparam int TBL_DEPTH        = MAX_MOTIF_LENGTH * ALPHABET_SIZE;
  localparam int TBL_ADDR_W       = COL_W + SYM_W;

  // field widths
  localparam int ENTRY_W     = 24;
  localparam int TBL_W       = ENTRY_W + 1;
  localparam int LEN_W       = 7;
  localparam int POS_W       = 24;
  localparam int OUT_SCORE_W = 30;
  localparam int ACC_W       = 31;

  localparam logic [LEN_W-1:0] LEN_RESET = 7'd8;
  localparam logic [LEN_W-1:0] LEN_MAX   = 7'd64;
  localparam logic [POS_W-1:0] POS_MAX   = 24'hFFFFFF;

  localparam logic signed [ACC_W-1:0] SCORE_HI = 31'sd536870911;
  localparam logic signed [ACC_W-1:0] SCORE_LO = -31'sd536870912;

  // action codes
  localparam logic ACTION_LOAD = 1'b0;
  localparam logic ACTION_SCAN = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load_we;    // write one table entry
    logic scan_take;  // accept a scan transaction
    logic issue;      // issue one table read
    logic out_load;   // move the finished result into the output register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_short;  // scan transaction yields no result
    logic issue_last;  // current read is the last column
    logic out_free;    // output register can take a result
  } ctrl_sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/pwm_window_scan_unit.sv
// pwm_window_scan_unit: position weight matrix scan, top level
// a load or a silent scan is done when it is accepted; a scan with a result reaches
// the output register after a window read, then a table read, for each column
// input stalls until the result enters the output register; output stalls delay that
// reset: synchronous active low; clears the window count, position, length (8) and
// handshake state; the motif table is undefined until loaded
`timescale 1ns / 1ps
`default_nettype none

module pwm_window_scan_unit (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // configuration: motif_length
  input  wire logic                                  cfg_we,
  input  wire logic [pws_pkg::LEN_W-1:0]             cfg_wdata,
  // input transaction channel
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic                                  in_action,
  input  wire logic [pws_pkg::COL_W-1:0]             in_column,
  input  wire logic [pws_pkg::SYM_W-1:0]             in_symbol,
  input  wire logic signed [pws_pkg::ENTRY_W-1:0]    in_entry_score,
  input  wire logic                                  in_entry_forbidden,
  input  wire logic                                  in_last_symbol,
  // result transaction channel
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic [pws_pkg::POS_W-1:0]                  out_window_start,
  output logic signed [pws_pkg::OUT_SCORE_W-1:0]     out_window_score,
  output logic                                       out_score_forbidden,
  output logic                                       out_last
);
  import pws_pkg::*;

  // command and status between the sequencer and the datapath
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // sequencer: takes a transaction only when idle, walks the window columns,
  // then parks the result in the output register once it is free
  pws_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_action (in_action),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: symbol window ram, motif table ram, score accumulator with
  // saturation, and the output register that decouples the result side
  pws_datapath u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_column           (in_column),
    .in_symbol           (in_symbol),
    .in_entry_score      (in_entry_score),
    .in_entry_forbidden  (in_entry_forbidden),
    .in_last_symbol      (in_last_symbol),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_window_start    (out_window_start),
    .out_window_score    (out_window_score),
    .out_score_forbidden (out_score_forbidden),
    .out_last            (out_last)
  );

endmodule

`default_nettype wire

>>> hw/rtl/pws_ram.sv
// pws_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module pws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/pws_datapath.sv
// pws_datapath: symbol window ram, motif table, accumulator and output register
// depends on pws_pkg and pws_ram
`timescale 1ns / 1ps
`default_nettype none

module pws_datapath (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire pws_pkg::ctrl_cmd_t                    cmd,
  output pws_pkg::ctrl_sts_t                         sts,
  input  wire logic [pws_pkg::COL_W-1:0]             in_column,
  input  wire logic [pws_pkg::SYM_W-1:0]             in_symbol,
  input  wire logic signed [pws_pkg::ENTRY_W-1:0]    in_entry_score,
  input  wire logic                                  in_entry_forbidden,
  input  wire logic                                  in_last_symbol,
  input  wire logic                                  cfg_we,
  input  wire logic [pws_pkg::LEN_W-1:0]             cfg_wdata,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic [pws_pkg::POS_W-1:0]                  out_window_start,
  output logic signed [pws_pkg::OUT_SCORE_W-1:0]     out_window_score,
  output logic                                       out_score_forbidden,
  output logic                                       out_last
);
  import pws_pkg::*;

  logic [LEN_W-1:0]          motif_length_r;
  logic [LEN_W-1:0]          eff_len;
  logic [LEN_W-1:0]          held_r, held_inc;
  logic [POS_W-1:0]          pos_r;
  logic [LEN_W-1:0]          len_r;
  logic                      last_r;
  logic [POS_W-1:0]          start_r, start_nxt;
  logic [COL_W-1:0]          wp_r;
  logic [COL_W-1:0]          base_r, base_nxt;
  logic [COL_W-1:0]          idx_r;
  logic [COL_W-1:0]          col_d_r;
  logic                      sym_valid_r;
  logic                      rd_valid_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic                      forb_r;
  logic [SYM_W-1:0]          win_rd;
  logic [COL_W-1:0]          win_raddr;
  logic [TBL_W-1:0]          rd_data;
  logic [TBL_ADDR_W-1:0]     raddr;
  logic signed [ACC_W-1:0]   sat_score;
  logic                      out_valid_r;

  // clamp the configured length into 1..MAX_MOTIF_LENGTH
  always_comb begin
    if (motif_length_r == '0) begin
      eff_len = LEN_W'(1);
    end else if (motif_length_r > LEN_MAX) begin
      eff_len = LEN_MAX;
    end else begin
      eff_len = motif_length_r;
    end
  end

  assign held_inc = (held_r < LEN_MAX) ? held_r + LEN_W'(1) : held_r;

  always_comb begin
    if (pos_r >= POS_W'(eff_len - LEN_W'(1))) begin
      start_nxt = pos_r - POS_W'(eff_len - LEN_W'(1));
    end else begin
      start_nxt = '0;
    end
  end

  // oldest symbol of the window sits len slots behind the write pointer
  assign base_nxt = wp_r + COL_W'(1) - eff_len[COL_W-1:0];

  // column i reads the symbol i places after the window's oldest
  assign win_raddr = base_r + idx_r;

  pws_ram #(
    .WIDTH (SYM_W),
    .DEPTH (MAX_MOTIF_LENGTH)
  ) u_window (
    .clk   (clk),
    .we    (cmd.scan_take),
    .waddr (wp_r),
    .wdata (in_symbol),
    .raddr (win_raddr),
    .rdata (win_rd)
  );

  assign raddr = {col_d_r, win_rd};

  pws_ram #(
    .WIDTH (TBL_W),
    .DEPTH (TBL_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (cmd.load_we),
    .waddr ({in_column, in_symbol}),
    .wdata ({in_entry_forbidden, in_entry_score}),
    .raddr (raddr),
    .rdata (rd_data)
  );

  always_comb begin
    if (acc_r > SCORE_HI) begin
      sat_score = SCORE_HI;
    end else if (acc_r < SCORE_LO) begin
      sat_score = SCORE_LO;
    end else begin
      sat_score = acc_r;
    end
  end

  assign sts.scan_short = (held_inc < eff_len);
  assign sts.issue_last = ({1'b0, idx_r} == len_r - LEN_W'(1));
  assign sts.out_free   = !out_valid_r || !out_stall;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      motif_length_r <= LEN_RESET;
      held_r         <= '0;
      pos_r          <= '0;
      wp_r           <= '0;
      sym_valid_r    <= 1'b0;
      rd_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        motif_length_r <= cfg_wdata;
      end
      if (cmd.scan_take) begin
        wp_r <= wp_r + COL_W'(1);
        if (in_last_symbol) begin
          held_r <= '0;
          pos_r  <= '0;
        end else begin
          held_r <= held_inc;
          if (pos_r < POS_MAX) begin
            pos_r <= pos_r + POS_W'(1);
          end
        end
      end
      sym_valid_r <= cmd.issue;
      rd_valid_r  <= sym_valid_r;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_stall == 1'b0) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.scan_take) begin
      base_r   <= base_nxt;
      len_r    <= eff_len;
      last_r   <= in_last_symbol;
      start_r  <= start_nxt;
      idx_r    <= '0;
      acc_r    <= '0;
      forb_r   <= 1'b0;
    end else begin
      if (cmd.issue) begin
        idx_r   <= idx_r + COL_W'(1);
        col_d_r <= idx_r;
      end
      if (rd_valid_r) begin
        if (rd_data[TBL_W-1]) begin
          forb_r <= 1'b1;
        end else begin
          acc_r <= acc_r + ACC_W'($signed(rd_data[ENTRY_W-1:0]));
        end
      end
    end
    if (cmd.out_load) begin
      out_window_start    <= start_r;
      out_window_score    <= forb_r ? '0 : sat_score[OUT_SCORE_W-1:0];
      out_score_forbidden <= forb_r;
      out_last            <= last_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

>>> hw/rtl/pws_ctrl.sv
// pws_ctrl: sequencing state machine for loads and window scans
// depends on pws_pkg
`timescale 1ns / 1ps
`default_nettype none

module pws_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_action,
  input  wire pws_pkg::ctrl_sts_t sts,
  output pws_pkg::ctrl_cmd_t      cmd
);
  import pws_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_RUN    = 3'd1;
  localparam logic [2:0] ST_DRAIN  = 3'd2;
  localparam logic [2:0] ST_SETTLE = 3'd3;
  localparam logic [2:0] ST_OUT    = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       take;

  assign in_stall = (state_r != ST_IDLE);
  assign take     = in_valid && (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cmd.load_we   = 1'b0;
    cmd.scan_take = 1'b0;
    cmd.issue     = 1'b0;
    cmd.out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (take) begin
          if (in_action == ACTION_LOAD) begin
            cmd.load_we = 1'b1;
          end else begin
            cmd.scan_take = 1'b1;
            if (!sts.scan_short) begin
              state_nxt = ST_RUN;
            end
          end
        end
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
        if (sts.issue_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      // last window symbol read is out, table read in flight
      ST_DRAIN: begin
        state_nxt = ST_SETTLE;
      end
      // last table entry lands in the accumulator
      ST_SETTLE: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> dv/pws_window_checker.sv
// pws_window_checker: watches the config port and both transaction channels of the
// window scan unit, predicts every window result and compares it field by field
// depends on pws_pkg
`timescale 1ns / 1ps

module pws_window_checker (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [pws_pkg::LEN_W-1:0]              cfg_wdata,
  input  logic                                   in_valid,
  input  logic                                   in_stall,
  input  logic                                   in_action,
  input  logic [pws_pkg::COL_W-1:0]              in_column,
  input  logic [pws_pkg::SYM_W-1:0]              in_symbol,
  input  logic signed [pws_pkg::ENTRY_W-1:0]     in_entry_score,
  input  logic                                   in_entry_forbidden,
  input  logic                                   in_last_symbol,
  input  logic                                   out_valid,
  input  logic                                   out_stall,
  input  logic [pws_pkg::POS_W-1:0]              out_window_start,
  input  logic signed [pws_pkg::OUT_SCORE_W-1:0] out_window_score,
  input  logic                                   out_score_forbidden,
  input  logic                                   out_last,
  output int                                     fail_count,
  output int                                     pending
);
  import pws_pkg::*;

  typedef struct packed {
    logic [POS_W-1:0]              start;
    logic signed [OUT_SCORE_W-1:0] score;
    logic                          forbidden;
    logic                          last;
  } window_result_t;

  logic signed [ENTRY_W-1:0] tbl_score [TBL_DEPTH];
  logic                      tbl_forbidden [TBL_DEPTH];
  logic [SYM_W-1:0]          recent_syms [MAX_MOTIF_LENGTH];
  int unsigned               held_count;
  logic [POS_W-1:0]          next_pos;
  logic [LEN_W-1:0]          motif_len;
  window_result_t            window_results_q [$];
  window_result_t            due;
  int                        load_idx;

  initial fail_count = 0;

  // shift one symbol into the window and queue the window score it completes
  task automatic scan_window(input logic [SYM_W-1:0] sym, input logic ends_seq);
    int unsigned    len_eff;
    int unsigned    col;
    int             idx;
    logic [POS_W-1:0] pos;
    longint         sum;
    logic           forb;
    logic [SYM_W-1:0] s;
    window_result_t res;
    for (int i = MAX_MOTIF_LENGTH - 1; i > 0; i--) recent_syms[i] = recent_syms[i - 1];
    recent_syms[0] = sym;
    if (held_count < MAX_MOTIF_LENGTH) held_count++;
    pos = next_pos;
    if (next_pos != POS_MAX) next_pos = next_pos + 1'b1;
    if (motif_len == 0) len_eff = 1;
    else if (motif_len > LEN_MAX) len_eff = MAX_MOTIF_LENGTH;
    else len_eff = motif_len;
    if (held_count >= len_eff) begin
      sum  = 0;
      forb = 1'b0;
      for (col = 0; col < len_eff; col++) begin
        s = recent_syms[len_eff - 1 - col];
        if (s >= ALPHABET_SIZE) begin
          forb = 1'b1;
        end else begin
          idx = col * ALPHABET_SIZE + s;
          if (tbl_forbidden[idx]) forb = 1'b1;
          else sum += tbl_score[idx];
        end
      end
      if (forb) sum = 0;
      if (sum > longint'(SCORE_HI)) sum = longint'(SCORE_HI);
      if (sum < longint'(SCORE_LO)) sum = longint'(SCORE_LO);
      res.start     = (pos >= len_eff - 1) ? POS_W'(pos - (len_eff - 1)) : '0;
      res.score     = sum[OUT_SCORE_W-1:0];
      res.forbidden = forb;
      res.last      = ends_seq;
      window_results_q.insert(window_results_q.size(), res);
    end
    // a last symbol restarts the window, with or without a result
    if (ends_seq) begin
      held_count = 0;
      next_pos   = '0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      window_results_q.delete();
      foreach (recent_syms[i]) recent_syms[i] = '0;
      held_count = 0;
      next_pos   = '0;
      motif_len  = LEN_RESET;
    end else begin
      if (out_valid && !out_stall) begin
        if (window_results_q.size() == 0) begin
          $error("unexpected window result: start %0d score %0d", out_window_start,
                 out_window_score);
          fail_count++;
        end else begin
          due = window_results_q.pop_front();
          if (out_window_start !== due.start) begin
            $error("window_start: expected %0d, actual %0d", due.start, out_window_start);
            fail_count++;
          end
          if (out_window_score !== due.score) begin
            $error("window_score: expected %0d, actual %0d", due.score, out_window_score);
            fail_count++;
          end
          if (out_score_forbidden !== due.forbidden) begin
            $error("score_forbidden: expected %0b, actual %0b", due.forbidden,
                   out_score_forbidden);
            fail_count++;
          end
          if (out_last !== due.last) begin
            $error("last: expected %0b, actual %0b", due.last, out_last);
            fail_count++;
          end
        end
      end
      if (cfg_we) motif_len = cfg_wdata;
      if (in_valid && !in_stall) begin
        if (in_action == ACTION_LOAD) begin
          if (in_column < MAX_MOTIF_LENGTH && in_symbol < ALPHABET_SIZE) begin
            load_idx = in_column * ALPHABET_SIZE + in_symbol;
            tbl_score[load_idx]     = in_entry_score;
            tbl_forbidden[load_idx] = in_entry_forbidden;
          end
        end else begin
          scan_window(in_symbol, in_last_symbol);
        end
      end
    end
    pending = window_results_q.size();
  end

endmodule

>>> dv/tb_pwm_window_scan_unit.sv
// tb_pwm_window_scan_unit: stimulus and verdict for the window scan unit
// depends on pws_pkg, pwm_window_scan_unit and pws_window_checker
`timescale 1ns / 1ps

module tb_pwm_window_scan_unit;
  import pws_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  // drain wait, longer than the longest scan with a result
  localparam int DRAIN_CYCLES = 80;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [LEN_W-1:0]              cfg_wdata;
  logic                          in_valid;
  logic                          in_stall;
  logic                          in_action;
  logic [COL_W-1:0]              in_column;
  logic [SYM_W-1:0]              in_symbol;
  logic signed [ENTRY_W-1:0]     in_entry_score;
  logic                          in_entry_forbidden;
  logic                          in_last_symbol;
  logic                          out_valid;
  logic                          out_stall;
  logic [POS_W-1:0]              out_window_start;
  logic signed [OUT_SCORE_W-1:0] out_window_score;
  logic                          out_score_forbidden;
  logic                          out_last;

  int fail_count;
  int pending;
  int cycle_count;

  // idling knobs, flipped per phase by the stimulus
  bit tx_gaps;
  bit rx_gaps;
  // long receiver hold-offs: stimulus bumps the request count, receiver serves it
  int hold_requests;
  int holds_served;

  // scan sequence in flight, kept across phases so length changes land mid-sequence
  int seq_count;
  int seq_target;
  int fixed_sym;

  pwm_window_scan_unit uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_action           (in_action),
    .in_column           (in_column),
    .in_symbol           (in_symbol),
    .in_entry_score      (in_entry_score),
    .in_entry_forbidden  (in_entry_forbidden),
    .in_last_symbol      (in_last_symbol),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_window_start    (out_window_start),
    .out_window_score    (out_window_score),
    .out_score_forbidden (out_score_forbidden),
    .out_last            (out_last)
  );

  pws_window_checker window_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_action           (in_action),
    .in_column           (in_column),
    .in_symbol           (in_symbol),
    .in_entry_score      (in_entry_score),
    .in_entry_forbidden  (in_entry_forbidden),
    .in_last_symbol      (in_last_symbol),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_window_start    (out_window_start),
    .out_window_score    (out_window_score),
    .out_score_forbidden (out_score_forbidden),
    .out_last            (out_last),
    .fail_count          (fail_count),
    .pending             (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run guard: a hung handshake ends here
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[pwm_window_scan_unit] ERROR");
    $finish;
  end

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!tx_gaps || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // scan symbols stay in the loaded rows 0..2, row 2 less often
  function automatic logic [SYM_W-1:0] pick_sym();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return SYM_W'(0);
    if (r < 8) return SYM_W'(1);
    return SYM_W'(2);
  endfunction

  // offer one transaction; called and returning at a falling edge, valid left high
  task automatic offer_txn(input logic act, input logic [COL_W-1:0] col,
                           input logic [SYM_W-1:0] sym, input logic signed [ENTRY_W-1:0] sc,
                           input logic forb, input logic ends_seq);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid           <= 1'b1;
    in_action          <= act;
    in_column          <= col;
    in_symbol          <= sym;
    in_entry_score     <= sc;
    in_entry_forbidden <= forb;
    in_last_symbol     <= ends_seq;
    // accepted at the first rising edge with stall low
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // scan transaction with random junk in the fields a scan ignores
  task automatic scan_sym(input logic [SYM_W-1:0] sym, input logic ends_seq);
    offer_txn(ACTION_SCAN, COL_W'($urandom_range(0, 63)), sym, ENTRY_W'($urandom),
              1'($urandom), ends_seq);
  endtask

  // drain every expected window, let a silent scan finish, then write motif_length
  task automatic settle_and_set_length(input logic [LEN_W-1:0] len);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // receiver: random stalls, long hold-off on request
  initial begin : receiver
    int r;
    int stall_run;
    out_stall = 1'b0;
    stall_run = 0;
    holds_served = 0;
    forever begin
      @(negedge clk);
      if (holds_served != hold_requests) begin
        // block fills up behind this and stalls its input
        holds_served++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (stall_run > 0) begin
        stall_run--;
      end else begin
        r = $urandom_range(0, 99);
        if (!rx_gaps || r < 70) begin
          out_stall <= 1'b0;
        end else begin
          out_stall <= 1'b1;
          stall_run = (r < 95) ? $urandom_range(0, 2) : $urandom_range(5, 40);
        end
      end
    end
  end

  initial begin : stimulus
    int col;
    int sym;
    int p;
    int n;
    int items;
    int eff;
    int r;
    logic signed [ENTRY_W-1:0] sc;
    logic forb;
    logic [LEN_W-1:0] phase_len [10];

    phase_len = '{7'd1, 7'd0, 7'd5, 7'd127, 7'd2, 7'd64, 7'd12, 7'd3, 7'd8, 7'd4};

    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_valid           = 1'b0;
    in_action          = ACTION_LOAD;
    in_column          = '0;
    in_symbol          = '0;
    in_entry_score     = '0;
    in_entry_forbidden = 1'b0;
    in_last_symbol     = 1'b0;
    tx_gaps            = 1'b0;
    rx_gaps            = 1'b1;
    hold_requests      = 0;
    seq_count          = 0;
    seq_target         = 0;
    fixed_sym          = -1;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // fill rows 0..2 of every column; scans only use these rows and the directed loads
    // row 0 all max, row 1 all min, row 2 random with a few forbidden (column 1 always)
    for (col = 0; col < MAX_MOTIF_LENGTH; col++) begin
      for (sym = 0; sym < 3; sym++) begin
        case (sym)
          0:       sc = {1'b0, {(ENTRY_W-1){1'b1}}};
          1:       sc = {1'b1, {(ENTRY_W-1){1'b0}}};
          default: sc = ENTRY_W'($urandom);
        endcase
        forb = (sym == 2) && (col == 1 || $urandom_range(0, 15) == 0);
        offer_txn(ACTION_LOAD, COL_W'(col), SYM_W'(sym), sc, forb, 1'($urandom));
      end
    end

    // directed: reset length of 8, all-max window
    tx_gaps = 1'b1;
    for (n = 0; n < 8; n++) scan_sym(5'd0, n == 7);
    // length 3: all-min window
    settle_and_set_length(7'd3);
    for (n = 0; n < 3; n++) scan_sym(5'd1, n == 2);
    // short sequence, no result but the window restarts
    scan_sym(5'd4, 1'b0);
    scan_sym(5'd9, 1'b1);
    // forbidden entry in the middle of the window forces a zero score
    scan_sym(5'd0, 1'b0);
    scan_sym(5'd2, 1'b0);
    scan_sym(5'd0, 1'b1);
    // loads at the field extremes, then a window that reads fresh entries
    offer_txn(ACTION_LOAD, 6'd63, 5'd31, {1'b0, {(ENTRY_W-1){1'b1}}}, 1'b0, 1'b1);
    offer_txn(ACTION_LOAD, 6'd0, 5'd31, {1'b1, {(ENTRY_W-1){1'b0}}}, 1'b1, 1'b0);
    offer_txn(ACTION_LOAD, 6'd0, 5'd30, ENTRY_W'($urandom), 1'b0, 1'b0);
    offer_txn(ACTION_LOAD, 6'd1, 5'd7, '0, 1'b0, 1'b0);
    offer_txn(ACTION_LOAD, 6'd2, 5'd5, '1, 1'b0, 1'b0);
    scan_sym(5'd31, 1'b0);
    scan_sym(5'd7, 1'b0);
    scan_sym(5'd5, 1'b1);
    scan_sym(5'd30, 1'b0);
    scan_sym(5'd7, 1'b0);
    scan_sym(5'd5, 1'b1);

    // back pressure: receiver holds off while scans keep coming back to back
    settle_and_set_length(7'd2);
    hold_requests++;
    tx_gaps = 1'b0;
    for (n = 0; n < 24; n++) scan_sym(pick_sym(), n % 8 == 7);

    // random phases over a sweep of lengths, zero and out-of-range among them
    for (p = 0; p < 10; p++) begin
      settle_and_set_length(phase_len[p]);
      if (phase_len[p] == 0) eff = 1;
      else if (phase_len[p] > LEN_MAX) eff = MAX_MOTIF_LENGTH;
      else eff = phase_len[p];
      items = (eff + 4 > 8) ? eff + 4 : 8;
      // some phases run without idling on one side or the other
      tx_gaps = (p % 3 != 1);
      rx_gaps = (p % 3 != 2);
      for (n = 0; n < items; n++) begin
        if ($urandom_range(0, 9) == 0) begin
          // rows 0 and 1 keep their extreme contents
          offer_txn(ACTION_LOAD, COL_W'($urandom_range(0, 63)), SYM_W'(2),
                    ENTRY_W'($urandom), $urandom_range(0, 7) == 0, 1'($urandom));
        end else begin
          if (seq_target == 0) begin
            // mostly sequences long enough to yield windows, some short or long
            r = $urandom_range(0, 9);
            if (r < 7) seq_target = eff + $urandom_range(0, 6);
            else if (r < 9) seq_target = $urandom_range(1, eff);
            else seq_target = $urandom_range(1, 3 * eff + 4);
            fixed_sym = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1) : -1;
          end
          scan_sym((fixed_sym >= 0) ? SYM_W'(fixed_sym) : pick_sym(),
                   seq_count + 1 >= seq_target);
          seq_count++;
          if (seq_count >= seq_target) begin
            seq_count  = 0;
            seq_target = 0;
          end
        end
      end
    end

    // drain and let any trailing result show up
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("[pwm_window_scan_unit] OK");
    end else begin
      $display("[pwm_window_scan_unit] ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/pws_pkg.sv
hw/rtl/pws_ram.sv
hw/rtl/pws_datapath.sv
hw/rtl/pws_ctrl.sv
hw/rtl/pwm_window_scan_unit.sv
dv/pws_window_checker.sv
dv/tb_pwm_window_scan_unit.sv
